>>> rtl/avr_pkg.sv
// Shared widths, constants, pipeline word type and arctangent table for the vector rotator.
package avr_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int ANGLE_W = 16;
  localparam int AXIS_W  = 2;
  localparam int OUT_W   = DATA_WIDTH + 1;
  localparam int FRAC    = 16;
  localparam int GAIN_W  = 31;
  localparam int PROD_W  = DATA_WIDTH + GAIN_W;
  localparam int ROT_W   = DATA_WIDTH + 20;
  localparam int Z_W     = 34;
  localparam int IDX_W   = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_PASS = 2'd3;

  localparam logic signed [GAIN_W-1:0] GAIN_Q30    = 31'sd652032874;
  localparam logic signed [Z_W-1:0]    PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0]    NEG_PI_Q30  = -34'sd3373259426;
  localparam logic signed [Z_W-1:0]    TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [Z_W-1:0]    HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [Z_W-1:0]    NEG_HALF_PI_Q30 = -34'sd1686629713;

  localparam int ATAN_HEAD_N = 11;
  localparam logic signed [Z_W-1:0] ATAN_HEAD [ATAN_HEAD_N] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516,  34'sd16775851,  34'sd8388437,   34'sd4194283,   34'sd2097149,
    34'sd1048576
  };

  // One word in flight through the rotator chain: the rotated pair, the
  // residual angle and the original vector for the unrotated outputs.
  typedef struct packed {
    logic signed [ROT_W-1:0]      a;
    logic signed [ROT_W-1:0]      b;
    logic signed [Z_W-1:0]        z;
    logic [AXIS_W-1:0]            axis;
    logic signed [DATA_WIDTH-1:0] px;
    logic signed [DATA_WIDTH-1:0] py;
    logic signed [DATA_WIDTH-1:0] pz;
  } stage_t;

  // round(atan(2^-i) * 2^30); exact powers of two past the head of the table
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [Z_W-1:0] r;
    r = '0;
    if (int'(i) < ATAN_HEAD_N) begin
      r = ATAN_HEAD[int'(i)];
    end else if (int'(i) <= 30) begin
      r = Z_W'(64'sd1 <<< (30 - int'(i)));
    end
    return r;
  endfunction

endpackage

>>> rtl/avr_in_if.sv
// Input channel: angle, axis code and vector with valid/ready.
interface avr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [avr_pkg::ANGLE_W-1:0]     angle;
  logic [avr_pkg::AXIS_W-1:0]             axis;
  logic signed [avr_pkg::DATA_WIDTH-1:0]  in_x;
  logic signed [avr_pkg::DATA_WIDTH-1:0]  in_y;
  logic signed [avr_pkg::DATA_WIDTH-1:0]  in_z;

  modport source(output valid, angle, axis, in_x, in_y, in_z, input ready);
  modport sink(input valid, angle, axis, in_x, in_y, in_z, output ready);
endinterface

>>> rtl/avr_out_if.sv
// Output channel: rotated vector with valid/ready.
interface avr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [avr_pkg::OUT_W-1:0] out_x;
  logic signed [avr_pkg::OUT_W-1:0] out_y;
  logic signed [avr_pkg::OUT_W-1:0] out_z;

  modport source(output valid, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface

>>> rtl/avr_prep.sv
// Front end: gain multiply and angle wrap, then quarter-turn and pipeline word setup.
module avr_prep (
  input  logic            clk,
  input  logic            rst,
  avr_in_if.sink          vec_in,
  output logic            out_valid,
  input  logic            out_ready,
  output avr_pkg::stage_t out_data
);

  typedef struct packed {
    logic signed [avr_pkg::PROD_W-1:0]     prod_a;
    logic signed [avr_pkg::PROD_W-1:0]     prod_b;
    logic signed [avr_pkg::Z_W-1:0]        z;
    logic [avr_pkg::AXIS_W-1:0]            axis;
    logic signed [avr_pkg::DATA_WIDTH-1:0] px;
    logic signed [avr_pkg::DATA_WIDTH-1:0] py;
    logic signed [avr_pkg::DATA_WIDTH-1:0] pz;
  } prod_t;

  prod_t s1, s1_next;
  logic  s1_valid;
  logic  s1_ready;

  logic signed [avr_pkg::DATA_WIDTH-1:0] sel_a, sel_b;
  logic signed [avr_pkg::Z_W-1:0]        z0;
  logic signed [avr_pkg::ROT_W-1:0]      ga, gb;
  avr_pkg::stage_t                       s2_next;

  always_comb begin
    unique case (vec_in.axis)
      avr_pkg::AXIS_X: begin
        sel_a = vec_in.in_y;
        sel_b = vec_in.in_z;
      end
      avr_pkg::AXIS_Y: begin
        sel_a = vec_in.in_z;
        sel_b = vec_in.in_x;
      end
      default: begin
        sel_a = vec_in.in_x;
        sel_b = vec_in.in_y;
      end
    endcase
    s1_next.prod_a = avr_pkg::PROD_W'(sel_a) * avr_pkg::PROD_W'(avr_pkg::GAIN_Q30);
    s1_next.prod_b = avr_pkg::PROD_W'(sel_b) * avr_pkg::PROD_W'(avr_pkg::GAIN_Q30);
    // Q3.13 to Q.30, then fold into -pi..pi once
    z0 = avr_pkg::Z_W'(vec_in.angle) <<< 17;
    if (z0 > avr_pkg::PI_Q30) begin
      s1_next.z = z0 - avr_pkg::TWO_PI_Q30;
    end else if (z0 < avr_pkg::NEG_PI_Q30) begin
      s1_next.z = z0 + avr_pkg::TWO_PI_Q30;
    end else begin
      s1_next.z = z0;
    end
    s1_next.axis = vec_in.axis;
    s1_next.px   = vec_in.in_x;
    s1_next.py   = vec_in.in_y;
    s1_next.pz   = vec_in.in_z;
  end

  assign vec_in.ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (vec_in.ready) begin
      s1_valid <= vec_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vec_in.valid && vec_in.ready) begin
      s1 <= s1_next;
    end
  end

  always_comb begin
    ga = avr_pkg::ROT_W'(s1.prod_a >>> (30 - avr_pkg::FRAC));
    gb = avr_pkg::ROT_W'(s1.prod_b >>> (30 - avr_pkg::FRAC));
    s2_next      = '0;
    s2_next.axis = s1.axis;
    s2_next.px   = s1.px;
    s2_next.py   = s1.py;
    s2_next.pz   = s1.pz;
    // Exact quarter turn when the angle is beyond +/-pi/2
    if (s1.z > avr_pkg::HALF_PI_Q30) begin
      s2_next.a = -gb;
      s2_next.b = ga;
      s2_next.z = s1.z - avr_pkg::HALF_PI_Q30;
    end else if (s1.z < avr_pkg::NEG_HALF_PI_Q30) begin
      s2_next.a = gb;
      s2_next.b = -ga;
      s2_next.z = s1.z + avr_pkg::HALF_PI_Q30;
    end else begin
      s2_next.a = ga;
      s2_next.b = gb;
      s2_next.z = s1.z;
    end
  end

  assign s1_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      out_data <= s2_next;
    end
  end

endmodule

>>> rtl/avr_cell.sv
// One CORDIC micro-rotation cell with its own word register.
module avr_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [avr_pkg::IDX_W-1:0]  idx,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  avr_pkg::stage_t            in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output avr_pkg::stage_t            out_data
);

  logic signed [avr_pkg::ROT_W-1:0] da, db;
  logic signed [avr_pkg::Z_W-1:0]   step;
  avr_pkg::stage_t                  nxt;

  always_comb begin
    nxt  = in_data;
    da   = in_data.b >>> idx;
    db   = in_data.a >>> idx;
    step = avr_pkg::atan_q30(idx);
    // rotate forward on a non-negative residual
    if (!in_data.z[avr_pkg::Z_W-1]) begin
      nxt.a = in_data.a - da;
      nxt.b = in_data.b + db;
      nxt.z = in_data.z - step;
    end else begin
      nxt.a = in_data.a + da;
      nxt.b = in_data.b - db;
      nxt.z = in_data.z + step;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

>>> rtl/avr_finish.sv
// Output stage: round, saturate, map the pair back to x/y/z and hold the word.
module avr_finish (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  avr_pkg::stage_t in_data,
  avr_out_if.source       vec_out
);

  localparam logic signed [avr_pkg::ROT_W-1:0] ROUND   = avr_pkg::ROT_W'(1) <<< (avr_pkg::FRAC - 1);
  localparam logic signed [avr_pkg::ROT_W-1:0] SAT_MAX =
    avr_pkg::ROT_W'((64'sd1 <<< (avr_pkg::OUT_W - 1)) - 64'sd1);
  localparam logic signed [avr_pkg::ROT_W-1:0] SAT_MIN = -SAT_MAX - avr_pkg::ROT_W'(1);

  function automatic logic signed [avr_pkg::OUT_W-1:0] round_sat(
    input logic signed [avr_pkg::ROT_W-1:0] v
  );
    logic signed [avr_pkg::ROT_W-1:0] r;
    r = (v + ROUND) >>> avr_pkg::FRAC;
    if (r > SAT_MAX) begin
      r = SAT_MAX;
    end else if (r < SAT_MIN) begin
      r = SAT_MIN;
    end
    return avr_pkg::OUT_W'(r);
  endfunction

  logic signed [avr_pkg::OUT_W-1:0] ra, rb, ox, oy, oz;
  logic signed [avr_pkg::OUT_W-1:0] ex, ey, ez;

  always_comb begin
    ra = round_sat(in_data.a);
    rb = round_sat(in_data.b);
    ex = avr_pkg::OUT_W'(in_data.px);
    ey = avr_pkg::OUT_W'(in_data.py);
    ez = avr_pkg::OUT_W'(in_data.pz);
    unique case (in_data.axis)
      avr_pkg::AXIS_X: begin
        ox = ex;
        oy = ra;
        oz = rb;
      end
      avr_pkg::AXIS_Y: begin
        ox = rb;
        oy = ey;
        oz = ra;
      end
      avr_pkg::AXIS_Z: begin
        ox = ra;
        oy = rb;
        oz = ez;
      end
      default: begin
        ox = ex;
        oy = ey;
        oz = ez;
      end
    endcase
  end

  assign in_ready = !vec_out.valid || vec_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_out.valid <= 1'b0;
    end else if (in_ready) begin
      vec_out.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      vec_out.out_x <= ox;
      vec_out.out_y <= oy;
      vec_out.out_z <= oz;
    end
  end

endmodule

>>> rtl/axis_vector_rotator_core.sv
// Top level: rotates a 3-vector about x, y or z through a chain of CORDIC cells.
//
// vec_in carries one word per vector: angle (Q3.13 radians), axis code
// (x, y, z, or pass through) and the signed components in_x/in_y/in_z.
// vec_out returns the rotated vector out_x/out_y/out_z, one bit wider than
// the input, rounded and saturated. Both channels move a word on a clock
// edge where valid and ready are high.
//
// The pipeline is two front-end stages (gain multiply with angle fold, then
// quarter turn), one cell per CORDIC iteration, and the output register.
// Every stage holds its own word, so one vector enters and one leaves per
// cycle while vec_out is not stalled.
//
// Each stage advances when the next one is empty or advancing, so a stall
// on vec_out fills the chain from the back; vec_in.ready drops only once
// every stage holds a word. Reset (rst, synchronous) empties all stages;
// vec_out.valid is low after reset.
module axis_vector_rotator_core (
  input  logic      clk,
  input  logic      rst,
  avr_in_if.sink    vec_in,
  avr_out_if.source vec_out
);

  logic            c_valid [avr_pkg::CORDIC_STAGES+1];
  logic            c_ready [avr_pkg::CORDIC_STAGES+1];
  avr_pkg::stage_t c_data  [avr_pkg::CORDIC_STAGES+1];

  avr_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .vec_in    (vec_in),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_data  (c_data[0])
  );

  for (genvar g = 0; g < avr_pkg::CORDIC_STAGES; g++) begin : g_cell
    avr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (avr_pkg::IDX_W'(g)),
      .in_valid  (c_valid[g]),
      .in_ready  (c_ready[g]),
      .in_data   (c_data[g]),
      .out_valid (c_valid[g+1]),
      .out_ready (c_ready[g+1]),
      .out_data  (c_data[g+1])
    );
  end

  avr_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid[avr_pkg::CORDIC_STAGES]),
    .in_ready (c_ready[avr_pkg::CORDIC_STAGES]),
    .in_data  (c_data[avr_pkg::CORDIC_STAGES]),
    .vec_out  (vec_out)
  );

  // An empty output register means the whole chain can advance
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !vec_out.valid |-> vec_in.ready)
    else $error("input stalled while output register empty");

  // A ready output stage propagates ready to the head of the chain
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    c_ready[avr_pkg::CORDIC_STAGES] |-> c_ready[0])
    else $error("stall inside the cell chain with a free output stage");

  // A stalled front-end word holds until the first cell takes it
  a_prep_hold: assert property (@(posedge clk) disable iff (rst)
    c_valid[0] && !c_ready[0] |=> c_valid[0] && $stable(c_data[0]))
    else $error("front-end word lost or changed under stall");

endmodule
